@@ hw/rtl/gf_extension_field_alu_core_defines.svh @@
// assertion macros for the gf extension field alu
`ifndef GF_EXTENSION_FIELD_ALU_CORE_DEFINES_SVH
`define GF_EXTENSION_FIELD_ALU_CORE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define GFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication outside reset
`define GFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/gfa_pkg.sv @@
// ----------------------------------------------------------------------------
// gfa_pkg
// shared constants, types and codes of the gf(q^n) arithmetic unit
// ----------------------------------------------------------------------------
package gfa_pkg;

  localparam int MAX_DEGREE = 4;
  localparam int COEF_BITS  = 12;
  localparam int EXP_BITS   = 32;
  localparam int MOD_BITS   = 12;
  localparam int DEG_BITS   = 3;
  localparam int CFG_BITS   = 48;

  // operation codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_POW = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_MODULUS = 2'd0;
  localparam logic [1:0] CFG_DEGREE  = 2'd1;
  localparam logic [1:0] CFG_POLY    = 2'd2;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MAC,
    ST_FOLD,
    ST_ADDSUB,
    ST_POW_CHK,
    ST_DONE
  } state_t;

  // multiply request from sequencer to the mac unit
  typedef enum logic [1:0] {
    MU_MAC,
    MU_MODRED,
    MU_ADD
  } mu_op_t;

endpackage

@@ hw/rtl/gfa_stream_if.sv @@
// ----------------------------------------------------------------------------
// gfa_stream_if
// valid/ready channel carrying one payload of configurable width
// ----------------------------------------------------------------------------
interface gfa_stream_if #(
  parameter int WIDTH = 8
) ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/gfa_modred.sv @@
// ----------------------------------------------------------------------------
// gfa_modred
// multi-cycle restoring reduction of a value mod q, one quotient bit a cycle
// ----------------------------------------------------------------------------
module gfa_modred #(
  parameter int IN_BITS  = 32,
  parameter int MOD_BITS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [IN_BITS-1:0]  value,
  input  logic [MOD_BITS-1:0] modulus,
  output logic                done,
  output logic [MOD_BITS-1:0] rem
);
  localparam int CNT_BITS = $clog2(IN_BITS + 1);

  logic [IN_BITS-1:0]  val_r, val_nxt;
  logic [MOD_BITS:0]   rem_r, rem_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [MOD_BITS+1:0] shifted;

  // shift in one bit, subtract when it fits
  always_comb begin
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, val_r[IN_BITS-1]};
    if (start) begin
      val_nxt  = value;
      rem_nxt  = '0;
      cnt_nxt  = CNT_BITS'(IN_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      val_nxt = {val_r[IN_BITS-2:0], 1'b0};
      if (shifted >= {2'b00, modulus}) begin
        rem_nxt = (MOD_BITS+1)'(shifted - {2'b00, modulus});
      end else begin
        rem_nxt = shifted[MOD_BITS:0];
      end
      cnt_nxt = cnt_r - CNT_BITS'(1);
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    val_r <= val_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r[MOD_BITS-1:0];
endmodule

@@ hw/rtl/gf_extension_field_alu_core.sv @@
// gf_extension_field_alu_core: one item in flight, ready only when idle with no result held
// prep reduces 3*MAX_DEGREE raw coefficients in turn, one mod-q pass each; then add/sub
//   does n passes, multiply (2n^2-n) steps of one product plus a pass, and power up to
//   2*EXP_BITS multiplies
// the next transfer is accepted from the cycle after the result transfer completes
// synchronous active-low reset clears control state and loads q=3, n=2, x^2+2x+2
// ----------------------------------------------------------------------------
// gf_extension_field_alu_core
// gf(q^n) add, subtract, multiply and power over one shared mac and mod-q unit
// ----------------------------------------------------------------------------
module gf_extension_field_alu_core #(
  parameter int MAX_DEGREE = gfa_pkg::MAX_DEGREE,
  parameter int COEF_BITS  = gfa_pkg::COEF_BITS,
  parameter int EXP_BITS   = gfa_pkg::EXP_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  gfa_stream_if.sink   in_ch,
  gfa_stream_if.source out_ch,
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [MAX_DEGREE*COEF_BITS-1:0]      cfg_data
);
  localparam int EW     = MAX_DEGREE * COEF_BITS;
  localparam int PL     = 2 * MAX_DEGREE;
  localparam int IB     = 2 * COEF_BITS + 1;
  localparam int IDX_B  = $clog2(PL + 1);
  localparam int IN_W   = 2 + 2 * EW + EXP_BITS;
  localparam int EC_B   = $clog2(EXP_BITS + 1);

  // configuration registers
  logic [COEF_BITS-1:0] q_r;
  logic [2:0]           deg_r;
  logic [EW-1:0]        poly_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r    <= COEF_BITS'(3);
      deg_r  <= 3'd2;
      poly_r <= EW'(8194);
    end else if (cfg_we) begin
      case (cfg_index)
        gfa_pkg::CFG_MODULUS: q_r    <= cfg_data[COEF_BITS-1:0];
        gfa_pkg::CFG_DEGREE:  deg_r  <= cfg_data[2:0];
        gfa_pkg::CFG_POLY:    poly_r <= cfg_data[EW-1:0];
        default: ;
      endcase
    end
  end

  // effective modulus and degree
  logic [COEF_BITS-1:0] qe;
  logic [IDX_B-1:0]     ne;
  logic [IDX_B-1:0]     ne_m1;
  assign qe = (q_r == '0) ? COEF_BITS'(1) : q_r;
  always_comb begin
    if (deg_r == 3'd0) ne = IDX_B'(1);
    else if (32'(deg_r) > MAX_DEGREE) ne = IDX_B'(MAX_DEGREE);
    else ne = IDX_B'(deg_r);
  end
  assign ne_m1 = ne - IDX_B'(1);

  // working storage
  gfa_pkg::state_t      st_r, st_nxt;
  logic [1:0]           op_r;
  logic [COEF_BITS-1:0] a_r   [MAX_DEGREE];   // multiplier left operand
  logic [COEF_BITS-1:0] b_r   [MAX_DEGREE];   // multiplier right operand
  logic [COEF_BITS-1:0] base_r[MAX_DEGREE];   // power base
  logic [COEF_BITS-1:0] acc_r [MAX_DEGREE];   // power accumulator
  logic [COEF_BITS-1:0] rc_r  [MAX_DEGREE];   // (q - r_i) mod q
  logic [COEF_BITS-1:0] p_r   [PL];           // product buffer
  logic [EXP_BITS-1:0]  e_r;
  logic [EC_B-1:0]      ecnt_r;
  logic                 pmode_r;              // 0 acc*base, 1 base*base
  logic [IDX_B-1:0]     i_r, j_r, k_r;
  logic                 wait_r;
  logic [2*COEF_BITS-1:0] prod_r;
  logic [EW-1:0]        res_r;
  logic                 ovalid_r;
  logic [EW-1:0]        araw_r;               // raw first element
  logic [EW-1:0]        braw_r;               // raw second element
  // prep phase: raw coefficient reduction index
  logic [IDX_B+1:0]     pi_r;
  // the mac path registers the product in the cycle before reduction starts
  logic                 mac_go_r;
  logic                 issue;

  // shared mod-q unit
  logic                 mr_start;
  logic [IB-1:0]        mr_val;
  logic                 mr_done;
  logic [COEF_BITS-1:0] mr_rem;

  gfa_modred #(.IN_BITS(IB), .MOD_BITS(COEF_BITS)) u_modred (
    .clk(clk), .rst_n(rst_n), .start(mr_start), .value(mr_val),
    .modulus(qe), .done(mr_done), .rem(mr_rem)
  );

  logic [1:0]           in_op;
  logic [EW-1:0]        in_a, in_b;
  logic [EXP_BITS-1:0]  in_e;
  assign in_op = in_ch.data[IN_W-1 -: 2];
  assign in_a  = in_ch.data[IN_W-3 -: EW];
  assign in_b  = in_ch.data[EXP_BITS+EW-1 -: EW];
  assign in_e  = in_ch.data[EXP_BITS-1:0];

  assign in_ch.ready  = (st_r == gfa_pkg::ST_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = res_r;

  logic in_xfer;
  assign in_xfer = in_ch.valid && in_ch.ready;

  // prep walks 3*MAX_DEGREE raw coefficients: a, b, then poly
  localparam int PREP_N = 3 * MAX_DEGREE;
  logic [COEF_BITS-1:0] raw_coef;
  always_comb begin
    raw_coef = '0;
    for (int t = 0; t < MAX_DEGREE; t++) begin
      if (pi_r == (IDX_B+2)'(t))
        raw_coef = araw_r[COEF_BITS*t +: COEF_BITS];
      if (pi_r == (IDX_B+2)'(t + MAX_DEGREE))
        raw_coef = braw_r[COEF_BITS*t +: COEF_BITS];
      if (pi_r == (IDX_B+2)'(t + 2*MAX_DEGREE))
        raw_coef = poly_r[COEF_BITS*t +: COEF_BITS];
    end
  end

  // sequencer next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      gfa_pkg::ST_IDLE:    if (in_xfer) st_nxt = gfa_pkg::ST_PREP;
      gfa_pkg::ST_PREP:
        if (!wait_r && pi_r == (IDX_B+2)'(PREP_N)) begin
          if (op_r == gfa_pkg::OP_ADD || op_r == gfa_pkg::OP_SUB)
            st_nxt = gfa_pkg::ST_ADDSUB;
          else if (op_r == gfa_pkg::OP_MUL) st_nxt = gfa_pkg::ST_MAC;
          else st_nxt = gfa_pkg::ST_POW_CHK;
        end
      gfa_pkg::ST_ADDSUB:
        if (wait_r && mr_done && i_r == ne_m1) st_nxt = gfa_pkg::ST_DONE;
      gfa_pkg::ST_MAC:
        if (wait_r && mr_done && i_r == ne_m1 && j_r == ne_m1)
          st_nxt = (ne == IDX_B'(1)) ? gfa_pkg::ST_DONE : gfa_pkg::ST_FOLD;
      gfa_pkg::ST_FOLD:
        if (wait_r && mr_done && i_r == ne_m1 && k_r == ne)
          st_nxt = gfa_pkg::ST_DONE;
      gfa_pkg::ST_POW_CHK:
        if (ecnt_r == '0) st_nxt = gfa_pkg::ST_DONE;
        else st_nxt = gfa_pkg::ST_MAC;
      gfa_pkg::ST_DONE:
        if (op_r == gfa_pkg::OP_POW && ecnt_r != '0) st_nxt = gfa_pkg::ST_POW_CHK;
        else st_nxt = gfa_pkg::ST_IDLE;
      default: st_nxt = gfa_pkg::ST_IDLE;
    endcase
  end

  // operand selects for the shared mac
  logic [COEF_BITS-1:0] opa, opb;
  logic [COEF_BITS-1:0] pt_cur;
  always_comb begin
    opa = '0;
    opb = '0;
    pt_cur = '0;
    for (int t = 0; t < MAX_DEGREE; t++) begin
      if (i_r == IDX_B'(t)) opa = a_r[t];
      if (j_r == IDX_B'(t)) opb = b_r[t];
    end
    for (int t = 0; t < PL; t++) begin
      if (i_r + j_r == IDX_B'(t) && st_r == gfa_pkg::ST_MAC) pt_cur = p_r[t];
      if (k_r - ne + i_r == IDX_B'(t) && st_r == gfa_pkg::ST_FOLD) pt_cur = p_r[t];
    end
    if (st_r == gfa_pkg::ST_FOLD) begin
      opa = '0;
      opb = '0;
      for (int t = 0; t < PL; t++)
        if (k_r == IDX_B'(t)) opa = p_r[t];
      for (int t = 0; t < MAX_DEGREE; t++)
        if (i_r == IDX_B'(t)) opb = rc_r[t];
    end
  end

  // addsub operands
  logic [COEF_BITS-1:0] as_a, as_b;
  always_comb begin
    as_a = '0;
    as_b = '0;
    for (int t = 0; t < MAX_DEGREE; t++)
      if (i_r == IDX_B'(t)) begin
        as_a = a_r[t];
        as_b = b_r[t];
      end
  end

  // reduction input and start
  always_comb begin
    mr_start = 1'b0;
    mr_val   = '0;
    case (st_r)
      gfa_pkg::ST_PREP: begin
        mr_start = !wait_r && pi_r != (IDX_B+2)'(PREP_N);
        mr_val   = IB'(raw_coef);
      end
      gfa_pkg::ST_ADDSUB: begin
        mr_start = !wait_r;
        if (op_r == gfa_pkg::OP_ADD) mr_val = IB'(as_a) + IB'(as_b);
        else mr_val = IB'(as_a) + IB'(qe) - IB'(as_b);
      end
      gfa_pkg::ST_MAC, gfa_pkg::ST_FOLD: begin
        mr_start = mac_go_r;
        mr_val   = IB'(prod_r) + IB'(pt_cur);
      end
      default: ;
    endcase
  end

  // issue one product when the mod-q unit is free
  assign issue = (st_r == gfa_pkg::ST_MAC || st_r == gfa_pkg::ST_FOLD) &&
                 !wait_r && !mac_go_r &&
                 !(st_r == gfa_pkg::ST_FOLD && i_r == '0 && k_r < ne);

  // datapath and indices
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= gfa_pkg::ST_IDLE;
      ovalid_r <= 1'b0;
      wait_r   <= 1'b0;
      mac_go_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;
      mac_go_r <= issue;
      if (issue) prod_r <= (2*COEF_BITS)'(opa) * (2*COEF_BITS)'(opb);
      if (mr_start) wait_r <= 1'b1;
      else if (mr_done) wait_r <= 1'b0;

      case (st_r)
        gfa_pkg::ST_IDLE: begin
          if (in_xfer) begin
            araw_r <= in_a;
            braw_r <= in_b;
            op_r   <= in_op;
            e_r    <= in_e;
            pi_r   <= '0;
          end
        end
        gfa_pkg::ST_PREP: begin
          if (wait_r && mr_done) begin
            for (int t = 0; t < MAX_DEGREE; t++) begin
              if (pi_r == (IDX_B+2)'(t))
                a_r[t] <= (IDX_B'(t) < ne) ? mr_rem : '0;
              if (pi_r == (IDX_B+2)'(t + MAX_DEGREE))
                b_r[t] <= (IDX_B'(t) < ne) ? mr_rem : '0;
              if (pi_r == (IDX_B+2)'(t + 2*MAX_DEGREE))
                rc_r[t] <= (IDX_B'(t) >= ne || mr_rem == '0) ? '0 :
                           COEF_BITS'(qe - mr_rem);
            end
            pi_r <= pi_r + (IDX_B+2)'(1);
          end
          if (st_nxt != gfa_pkg::ST_PREP) begin
            i_r <= '0;
            j_r <= '0;
            k_r <= '0;
            for (int t = 0; t < PL; t++) p_r[t] <= '0;
            if (op_r == gfa_pkg::OP_POW) begin
              // accumulator starts at the constant 1 mod q
              for (int t = 0; t < MAX_DEGREE; t++) begin
                base_r[t] <= a_r[t];
                acc_r[t]  <= (t == 0 && qe != COEF_BITS'(1)) ? COEF_BITS'(1) : '0;
              end
              ecnt_r   <= EC_B'(EXP_BITS);
              pmode_r  <= 1'b0;
            end
          end
        end
        gfa_pkg::ST_ADDSUB: begin
          if (wait_r && mr_done) begin
            for (int t = 0; t < PL; t++)
              if (i_r == IDX_B'(t)) p_r[t] <= mr_rem;
            i_r <= i_r + IDX_B'(1);
          end
        end
        gfa_pkg::ST_MAC: begin
          if (wait_r && mr_done) begin
            for (int t = 0; t < PL; t++)
              if (i_r + j_r == IDX_B'(t)) p_r[t] <= mr_rem;
            if (j_r == ne_m1) begin
              j_r <= '0;
              if (i_r == ne_m1) begin
                i_r <= '0;
                k_r <= IDX_B'(2) * ne - IDX_B'(2);
              end else i_r <= i_r + IDX_B'(1);
            end else j_r <= j_r + IDX_B'(1);
          end
        end
        gfa_pkg::ST_FOLD: begin
          if (wait_r && mr_done) begin
            for (int t = 0; t < PL; t++)
              if (k_r - ne + i_r == IDX_B'(t)) p_r[t] <= mr_rem;
            if (i_r == ne_m1) begin
              i_r <= '0;
              for (int t = 0; t < PL; t++)
                if (k_r == IDX_B'(t)) p_r[t] <= '0;
              k_r <= k_r - IDX_B'(1);
            end else i_r <= i_r + IDX_B'(1);
          end
        end
        gfa_pkg::ST_POW_CHK: begin
          i_r <= '0;
          j_r <= '0;
          for (int t = 0; t < PL; t++) p_r[t] <= '0;
          if (ecnt_r != '0) begin
            if (!pmode_r && e_r[0]) begin
              for (int t = 0; t < MAX_DEGREE; t++) begin
                a_r[t] <= acc_r[t];
                b_r[t] <= base_r[t];
              end
            end else begin
              pmode_r <= 1'b1;
              for (int t = 0; t < MAX_DEGREE; t++) begin
                a_r[t] <= base_r[t];
                b_r[t] <= base_r[t];
              end
            end
          end
        end
        gfa_pkg::ST_DONE: begin
          if (op_r == gfa_pkg::OP_POW) begin
            if (ecnt_r != '0) begin
              if (pmode_r) begin
                for (int t = 0; t < MAX_DEGREE; t++) base_r[t] <= p_r[t];
                pmode_r <= 1'b0;
                e_r     <= e_r >> 1;
                ecnt_r  <= ecnt_r - EC_B'(1);
              end else begin
                for (int t = 0; t < MAX_DEGREE; t++) acc_r[t] <= p_r[t];
                pmode_r <= 1'b1;
              end
            end else begin
              for (int t = 0; t < MAX_DEGREE; t++)
                res_r[COEF_BITS*t +: COEF_BITS] <= (IDX_B'(t) < ne) ? acc_r[t] : '0;
              ovalid_r <= 1'b1;
            end
          end else begin
            for (int t = 0; t < MAX_DEGREE; t++)
              res_r[COEF_BITS*t +: COEF_BITS] <= (IDX_B'(t) < ne) ? p_r[t] : '0;
            ovalid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

@@ hw/rtl/gfa_checker.sv @@
// ----------------------------------------------------------------------------
// gfa_checker
// port-level checks of the gf(q^n) arithmetic unit, bound to the top level
// ----------------------------------------------------------------------------
`include "gf_extension_field_alu_core_defines.svh"

module gfa_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [47:0] out_data
);
  // nothing accepted while a result waits
  `GFA_ASSERT_IMPL(a_no_in_with_out, clk, rst_n, out_valid, !in_ready)
  // accepted transfer is followed by a busy cycle
  `GFA_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready)
  // stalled result holds
  `GFA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                   out_valid && $stable(out_data))
  // a result leaves a free slot behind
  `GFA_ASSERT_NEXT(a_out_drop, clk, rst_n, out_valid && out_ready, !out_valid)
endmodule

bind gf_extension_field_alu_core gfa_checker u_gfa_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

@@ tb/gf_extension_field_alu_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gf_extension_field_alu_core_tb
// self-checking bench for the gf(q^n) arithmetic unit: drives add, subtract,
// multiply and power items under several field settings and idle patterns,
// predicts every result in polynomial-basis arithmetic and compares in order
// ----------------------------------------------------------------------------
module gf_extension_field_alu_core_tb;

  localparam int MAX_DEG = gfa_pkg::MAX_DEGREE;
  localparam int COEF_W  = gfa_pkg::COEF_BITS;
  localparam int EXP_W   = gfa_pkg::EXP_BITS;
  localparam int MOD_W   = gfa_pkg::MOD_BITS;
  localparam int DEG_W   = gfa_pkg::DEG_BITS;
  localparam int ELEM_W  = MAX_DEG * COEF_W;
  localparam int ITEM_W  = 2 + 2 * ELEM_W + EXP_W;
  localparam int STALL_LIMIT = 400000;

  typedef longint unsigned coef_vec_t [MAX_DEG];

  // idle pattern of the current phase
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // in-order store of predicted field elements
  class element_scoreboard;
    logic [ELEM_W-1:0] pending[$];
    int errors;

    function void note(logic [ELEM_W-1:0] value);
      pending = {pending, value};
    endfunction

    task report(string what, logic [ELEM_W-1:0] got, logic [ELEM_W-1:0] want);
      errors++;
      $display("tb: mismatch %s got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    task check(logic [ELEM_W-1:0] got);
      logic [ELEM_W-1:0] want;
      if (pending.size() == 0) begin
        report("unexpected result", got, '0);
      end else begin
        want = pending.pop_front();
        if (got !== want) report("result_element", got, want);
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [ELEM_W-1:0] cfg_data;

  gfa_stream_if #(.WIDTH(ITEM_W)) in_ch ();
  gfa_stream_if #(.WIDTH(ELEM_W)) out_ch ();

  gf_extension_field_alu_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  element_scoreboard sb;

  // shadow copies of the configuration registers
  logic [MOD_W-1:0]  q_reg;
  logic [DEG_W-1:0]  n_reg;
  logic [ELEM_W-1:0] poly_reg;

  idle_mode_t idle_mode;
  int quiet_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // polynomial product reduced by the monic reduction polynomial
  function automatic coef_vec_t field_mul(coef_vec_t u, coef_vec_t v, coef_vec_t r, int n,
                                          longint unsigned q);
    longint unsigned p [2*MAX_DEG];
    longint unsigned t;
    coef_vec_t o;
    for (int i = 0; i < 2*MAX_DEG; i++) p[i] = 0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        p[i+j] = (p[i+j] + u[i] * v[j]) % q;
    // fold x^k for k >= n using x^n = -sum r_i x^i
    for (int k = 2*n - 2; k >= n; k--) begin
      t = p[k];
      p[k] = 0;
      for (int i = 0; i < n; i++)
        p[k-n+i] = (p[k-n+i] + t * ((q - r[i]) % q)) % q;
    end
    for (int i = 0; i < MAX_DEG; i++) o[i] = (i < n) ? p[i] : 64'd0;
    return o;
  endfunction

  function automatic logic [ELEM_W-1:0] predict_element(logic [1:0] op, logic [ELEM_W-1:0] x,
                                                        logic [ELEM_W-1:0] y,
                                                        logic [EXP_W-1:0] e);
    longint unsigned q;
    int n;
    coef_vec_t a, b, r, res;
    logic [ELEM_W-1:0] packed_res;
    q = (q_reg == '0) ? 64'd1 : 64'(q_reg);
    n = (n_reg == '0) ? 1 : ((int'(n_reg) > MAX_DEG) ? MAX_DEG : int'(n_reg));
    for (int i = 0; i < MAX_DEG; i++) begin
      a[i] = (i < n) ? 64'(x[i*COEF_W +: COEF_W]) % q : 64'd0;
      b[i] = (i < n) ? 64'(y[i*COEF_W +: COEF_W]) % q : 64'd0;
      r[i] = (i < n) ? 64'(poly_reg[i*COEF_W +: COEF_W]) % q : 64'd0;
      res[i] = 0;
    end
    case (op)
      gfa_pkg::OP_ADD: for (int i = 0; i < n; i++) res[i] = (a[i] + b[i]) % q;
      gfa_pkg::OP_SUB: for (int i = 0; i < n; i++) res[i] = (a[i] + (q - b[i])) % q;
      gfa_pkg::OP_MUL: res = field_mul(a, b, r, n, q);
      default: begin
        // square-and-multiply from the low exponent bit
        res[0] = 64'd1 % q;
        for (int k = 0; k < EXP_W; k++) begin
          if (e[k]) res = field_mul(res, a, r, n, q);
          a = field_mul(a, a, r, n, q);
        end
      end
    endcase
    packed_res = '0;
    for (int i = 0; i < n; i++) packed_res[i*COEF_W +: COEF_W] = res[i][COEF_W-1:0];
    return packed_res;
  endfunction

  // one register write; the caller drops the write enable
  task automatic write_reg(logic [1:0] idx, logic [ELEM_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      gfa_pkg::CFG_MODULUS: q_reg = value[MOD_W-1:0];
      gfa_pkg::CFG_DEGREE:  n_reg = value[DEG_W-1:0];
      gfa_pkg::CFG_POLY:    poly_reg = value;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_field(int unsigned q, int unsigned n, logic [ELEM_W-1:0] poly);
    wait_drained();
    write_reg(gfa_pkg::CFG_MODULUS, ELEM_W'(q));
    write_reg(gfa_pkg::CFG_DEGREE, ELEM_W'(n));
    write_reg(gfa_pkg::CFG_POLY, poly);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // one transfer on the input channel, then an optional sender gap
  task automatic send_item(logic [1:0] op, logic [ELEM_W-1:0] x, logic [ELEM_W-1:0] y,
                           logic [EXP_W-1:0] e);
    int unsigned gap_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 77 : 14;
    in_ch.valid <= 1'b1;
    in_ch.data  <= {op, x, y, e};
    do @(posedge clk); while (!in_ch.ready);
    sb.note(predict_element(op, x, y, e));
    if ((idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) &&
        $urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk);
      while ($urandom_range(99) < gap_pct);
    end
  endtask

  function automatic logic [ELEM_W-1:0] rand_word();
    return ELEM_W'({$urandom, $urandom});
  endfunction

  function automatic logic [ELEM_W-1:0] rand_element();
    logic [ELEM_W-1:0] v;
    longint unsigned q;
    q = (q_reg == '0) ? 64'd1 : 64'(q_reg);
    case ($urandom_range(9))
      0: v = '1;
      1: v = '0;
      2, 3, 4, 5: v = rand_word();
      default: for (int i = 0; i < MAX_DEG; i++)
        v[i*COEF_W +: COEF_W] = COEF_W'($urandom_range(32'(q - 64'd1)));
    endcase
    return v;
  endfunction

  task automatic send_random(int count);
    logic [1:0] op;
    logic [EXP_W-1:0] e;
    int unsigned pick, pow_pct;
    for (int k = 0; k < count; k++) begin
      // power is slow, keep it rare on the wide fields and on degree zero
      pow_pct = (n_reg >= 3 || n_reg == 0) ? 2 : 7;
      pick = $urandom_range(99);
      if (pick < pow_pct) op = gfa_pkg::OP_POW;
      else if (pick < 35) op = gfa_pkg::OP_ADD;
      else if (pick < 65) op = gfa_pkg::OP_SUB;
      else op = gfa_pkg::OP_MUL;
      case ($urandom_range(7))
        0: e = '0;
        1: e = '1;
        2: e = EXP_W'($urandom_range(15));
        default: e = EXP_W'($urandom);
      endcase
      send_item(op, rand_element(), rand_element(), e);
    end
    in_ch.valid <= 1'b0;
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      case (idle_mode)
        IDLE_RECEIVER: out_ch.ready <= ($urandom_range(99) >= 77);
        IDLE_BOTH:     out_ch.ready <= ($urandom_range(99) >= 14);
        default:       out_ch.ready <= 1'b1;
      endcase
    end
  end

  // result checking and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check(out_ch.data);
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  initial begin
    sb = new();
    idle_mode    = IDLE_NONE;
    quiet_cycles = 0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = gfa_pkg::CFG_MODULUS;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    q_reg    = 12'd3;
    n_reg    = 3'd2;
    poly_reg = 48'h2002;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items on the reset field x^2 + 2x + 2 over q = 3
    send_item(gfa_pkg::OP_ADD, '0, '0, '0);
    send_item(gfa_pkg::OP_ADD, '1, '1, '1);
    send_item(gfa_pkg::OP_SUB, '0, '1, '0);
    send_item(gfa_pkg::OP_SUB, 48'h001_002, 48'h002_001, '0);
    send_item(gfa_pkg::OP_MUL, 48'h001_000, 48'h001_000, '0);
    send_item(gfa_pkg::OP_MUL, '1, '1, '0);
    send_item(gfa_pkg::OP_MUL, 48'hfff_fff_002_001, 48'h123_456_001_002, '1);
    send_item(gfa_pkg::OP_POW, '0, '1, '0);
    send_item(gfa_pkg::OP_POW, '1, '0, '0);
    send_item(gfa_pkg::OP_POW, 48'h001_000, '0, 32'd8);
    send_item(gfa_pkg::OP_POW, 48'h001_001, '0, '1);
    send_item(gfa_pkg::OP_POW, '0, '0, 32'd5);
    send_item(gfa_pkg::OP_POW, 48'h001_002, '0, 32'h8000_0001);
    in_ch.valid <= 1'b0;

    // hold off until everything is back
    wait_drained();
    send_random(100);

    set_field(2, 1, rand_word());
    idle_mode = IDLE_SENDER;
    send_random(90);

    set_field(4095, 4, '1);
    idle_mode = IDLE_RECEIVER;
    send_random(50);

    set_field(7, 3, rand_word());
    idle_mode = IDLE_BOTH;
    send_random(50);
    wait_drained();
    send_random(50);

    // modulus zero and degree zero
    set_field(0, 0, rand_word());
    idle_mode = IDLE_NONE;
    send_random(60);

    // modulus one, degree above the maximum
    set_field(1, 7, rand_word());
    idle_mode = IDLE_SENDER;
    send_random(50);

    set_field(251, 4, rand_word());
    idle_mode = IDLE_RECEIVER;
    send_random(70);

    set_field(2, 2, 48'h0000_0000_0001);
    idle_mode = IDLE_BOTH;
    send_random(90);

    set_field(4093, 1, rand_word());
    idle_mode = IDLE_NONE;
    send_random(127);

    wait_drained();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
